### rtl/core/msis_pkg.sv
// Shared types and codes for the MIPS subset instruction step block.
// Used by msis_front, msis_queue, msis_back and the top level; no dependencies.
package msis_pkg;

  localparam int unsigned NREGS          = 32;
  localparam int unsigned DMEM_WORDS_DEF = 32;

  // Command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_LDREG = 2'd1,
    CMD_LDMEM = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type function codes
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_NOR = 6'd39;
  localparam logic [5:0] FN_SLT = 6'd42;

  // Classified operation kind, as handed from front to back
  typedef enum logic [3:0] {
    K_ALU,
    K_LW,
    K_SW,
    K_BEQ,
    K_J,
    K_ILL,
    K_LDREG,
    K_LDMEM,
    K_NONE
  } kind_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOR,
    ALU_SLT
  } alu_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] instr;
    logic [4:0]  load_index;
    logic [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        reg_we;
    logic [4:0]  reg_idx;
    logic [31:0] reg_val;
    logic        mem_we;
    logic [4:0]  mem_idx;
    logic [31:0] mem_val;
    logic        taken;
    logic        illegal;
  } out_item_t;

  // Decoded transaction held in the queue
  typedef struct packed {
    kind_e       kind;
    alu_e        alu;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic        use_rs;
    logic        use_rt;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [25:0] target;
    logic [4:0]  lidx;
    logic [31:0] lval;
  } dec_t;

endpackage

### rtl/core/msis_front.sv
// Front end: input handshake and instruction/command classification.
// Depends on msis_pkg; feeds msis_queue.
module msis_front import msis_pkg::*; (
  input  logic     valid_i,
  output logic     stall_o,
  input  in_item_t data_i,
  input  logic     q_full_i,
  input  logic     clr_busy_i,
  output logic     push_o,
  output dec_t     push_data_o
);

  logic [5:0] op;
  logic [5:0] fn;
  logic [4:0] rt;
  logic [4:0] rd;

  assign op = data_i.instr[31:26];
  assign fn = data_i.instr[5:0];
  assign rt = data_i.instr[20:16];
  assign rd = data_i.instr[15:11];

  assign stall_o = q_full_i | clr_busy_i;
  assign push_o  = valid_i & ~stall_o;

  always_comb begin
    push_data_o        = '0;
    push_data_o.kind   = K_NONE;
    push_data_o.alu    = ALU_ADD;
    push_data_o.rs     = data_i.instr[25:21];
    push_data_o.rt     = rt;
    push_data_o.target = data_i.instr[25:0];
    push_data_o.lidx   = data_i.load_index;
    push_data_o.lval   = data_i.load_value;
    case (data_i.cmd)
      CMD_LDREG: begin
        push_data_o.kind   = K_LDREG;
        push_data_o.wr_en  = (data_i.load_index != 5'd0);
        push_data_o.wr_idx = data_i.load_index;
      end
      CMD_LDMEM: begin
        push_data_o.kind = K_LDMEM;
      end
      CMD_EXEC: begin
        case (op)
          OP_RTYPE: begin
            push_data_o.kind   = K_ALU;
            push_data_o.use_rs = 1'b1;
            push_data_o.use_rt = 1'b1;
            push_data_o.wr_en  = (rd != 5'd0);
            push_data_o.wr_idx = rd;
            case (fn)
              FN_ADD: push_data_o.alu = ALU_ADD;
              FN_SUB: push_data_o.alu = ALU_SUB;
              FN_AND: push_data_o.alu = ALU_AND;
              FN_OR:  push_data_o.alu = ALU_OR;
              FN_NOR: push_data_o.alu = ALU_NOR;
              FN_SLT: push_data_o.alu = ALU_SLT;
              default: begin
                // unsupported funct: no register access at all
                push_data_o.kind   = K_ILL;
                push_data_o.use_rs = 1'b0;
                push_data_o.use_rt = 1'b0;
                push_data_o.wr_en  = 1'b0;
                push_data_o.wr_idx = 5'd0;
              end
            endcase
          end
          OP_LW: begin
            push_data_o.kind   = K_LW;
            push_data_o.use_rs = 1'b1;
            push_data_o.wr_en  = (rt != 5'd0);
            push_data_o.wr_idx = rt;
          end
          OP_SW: begin
            push_data_o.kind   = K_SW;
            push_data_o.use_rs = 1'b1;
            push_data_o.use_rt = 1'b1;
          end
          OP_BEQ: begin
            push_data_o.kind   = K_BEQ;
            push_data_o.use_rs = 1'b1;
            push_data_o.use_rt = 1'b1;
          end
          OP_J: begin
            push_data_o.kind = K_J;
          end
          default: begin
            push_data_o.kind = K_ILL;
          end
        endcase
      end
      default: begin
        push_data_o.kind = K_NONE;
      end
    endcase
  end

endmodule

### rtl/core/msis_queue.sv
// Two-entry queue of decoded transactions between front and back.
// Depends on msis_pkg.
module msis_queue import msis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  dec_t push_data_i,
  output logic full_o,
  output logic valid_o,
  output dec_t data_o,
  input  logic pop_i
);

  localparam int unsigned Depth = 2;

  dec_t       mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'(Depth));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count did not follow a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(Depth))
    else $error("queue count beyond depth");

endmodule

### rtl/core/msis_back.sv
// Back end: register file, execute stage, data memory index and access, output register.
// Depends on msis_pkg; takes decoded transactions from msis_queue.
module msis_back import msis_pkg::*; #(
  parameter int unsigned DMEM_WORDS = DMEM_WORDS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  dec_t      q_data_i,
  output logic      q_pop_o,
  output logic      clr_busy_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  localparam int unsigned AW    = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
  localparam int unsigned CLR_N = (DMEM_WORDS > NREGS) ? DMEM_WORDS : NREGS;
  localparam int unsigned CW    = $clog2(CLR_N);
  // floor(2^32 / DMEM_WORDS): estimate of the quotient is exact or one low
  localparam logic [30:0] RECIP = 31'((64'd1 << 32) / DMEM_WORDS);
  localparam logic [16:0] DIV   = 17'(DMEM_WORDS);

  typedef struct packed {
    kind_e       kind;
    logic [31:0] pc_after;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    logic [31:0] st_val;
    logic [29:0] x;
    logic        taken;
    logic        illegal;
  } ex_t;

  // clearing sweep
  logic          clr_busy_q;
  logic [CW-1:0] clr_cnt_q;
  logic          clr_rf;
  logic          clr_dm;

  // pipeline control
  logic v2_q, v3_q, v4_q, v5_q;
  logic adv, hazard, s2_move, s2_load;
  logic [31:0] pc_q;

  // payload
  dec_t        s2_q;
  logic [31:0] rd_a_q, rd_b_q;
  ex_t         ex_c, ex3_q, ex4_q;
  logic [60:0] mul_c, prod3_q;
  logic [28:0] quo3;
  logic [45:0] qd_c;
  logic [29:0] qd4_q;
  logic [29:0] rem_c, rem_fix;
  logic [AW-1:0] widx;
  out_item_t   s5_q, out_c;
  logic        lw5_q;
  logic [31:0] rdata_q;

  // stores
  logic [31:0] rf_q [NREGS];
  logic [31:0] dm_q [DMEM_WORDS];
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic [4:0]  ra_a, ra_b;
  logic        dm_we;
  logic [AW-1:0] dm_wa;
  logic [31:0] dm_wd;
  logic        st4;

  // operands and execute
  logic [31:0] op_a, op_b, imm32, seq, alu_r, addr;
  logic        ld_hit_a, ld_hit_b;

  // ---------------- clearing sweep ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == CW'(CLR_N - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + CW'(1);
      end
    end
  end

  assign clr_busy_o = clr_busy_q;
  assign clr_rf = clr_busy_q && ({1'b0, clr_cnt_q} < (CW + 1)'(NREGS));
  assign clr_dm = clr_busy_q && ({1'b0, clr_cnt_q} < (CW + 1)'(DMEM_WORDS));

  // ---------------- flow control ----------------
  assign adv     = !v5_q || !out_stall_i;
  assign s2_move = adv && !hazard;
  assign s2_load = !v2_q || s2_move;
  assign q_pop_o = s2_load;

  // ---------------- register file ----------------
  assign ra_a  = s2_load ? q_data_i.rs : s2_q.rs;
  assign ra_b  = s2_load ? q_data_i.rt : s2_q.rt;
  assign rf_we = clr_rf || (v5_q && out_c.reg_we);
  assign rf_wa = clr_rf ? clr_cnt_q[4:0] : out_c.reg_idx;
  assign rf_wd = clr_rf ? 32'd0 : out_c.reg_val;

  // write-first read: the registered read sees this edge's writeback
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_wa] <= rf_wd;
    end
    rd_a_q <= (rf_we && rf_wa == ra_a) ? rf_wd : rf_q[ra_a];
    rd_b_q <= (rf_we && rf_wa == ra_b) ? rf_wd : rf_q[ra_b];
  end

  // ---------------- stage 2: operands, execute, pc ----------------
  // newest older write wins: s3 over s4 over the output register
  always_comb begin
    op_a = rd_a_q;
    op_b = rd_b_q;
    if (v5_q && out_c.reg_we && out_c.reg_idx == s2_q.rs) op_a = out_c.reg_val;
    if (v5_q && out_c.reg_we && out_c.reg_idx == s2_q.rt) op_b = out_c.reg_val;
    if (v4_q && ex4_q.wr_en && ex4_q.wr_idx == s2_q.rs) op_a = ex4_q.wr_val;
    if (v4_q && ex4_q.wr_en && ex4_q.wr_idx == s2_q.rt) op_b = ex4_q.wr_val;
    if (v3_q && ex3_q.wr_en && ex3_q.wr_idx == s2_q.rs) op_a = ex3_q.wr_val;
    if (v3_q && ex3_q.wr_en && ex3_q.wr_idx == s2_q.rt) op_b = ex3_q.wr_val;
  end

  // load data exists only once the load sits in the output register
  assign ld_hit_a = (v3_q && ex3_q.kind == K_LW && ex3_q.wr_en && ex3_q.wr_idx == s2_q.rs)
                 || (v4_q && ex4_q.kind == K_LW && ex4_q.wr_en && ex4_q.wr_idx == s2_q.rs);
  assign ld_hit_b = (v3_q && ex3_q.kind == K_LW && ex3_q.wr_en && ex3_q.wr_idx == s2_q.rt)
                 || (v4_q && ex4_q.kind == K_LW && ex4_q.wr_en && ex4_q.wr_idx == s2_q.rt);
  assign hazard = v2_q && ((s2_q.use_rs && ld_hit_a) || (s2_q.use_rt && ld_hit_b));

  assign imm32 = {{16{s2_q.target[15]}}, s2_q.target[15:0]};
  assign seq   = pc_q + 32'd4;
  assign addr  = op_a + imm32;

  always_comb begin
    case (s2_q.alu)
      ALU_ADD: alu_r = op_a + op_b;
      ALU_SUB: alu_r = op_a - op_b;
      ALU_AND: alu_r = op_a & op_b;
      ALU_OR:  alu_r = op_a | op_b;
      ALU_NOR: alu_r = ~(op_a | op_b);
      ALU_SLT: alu_r = {31'd0, $signed(op_a) < $signed(op_b)};
      default: alu_r = 32'd0;
    endcase
  end

  always_comb begin
    ex_c          = '0;
    ex_c.kind     = s2_q.kind;
    ex_c.pc_after = seq;
    ex_c.wr_en    = s2_q.wr_en;
    ex_c.wr_idx   = s2_q.wr_idx;
    case (s2_q.kind)
      K_ALU: begin
        ex_c.wr_val = alu_r;
      end
      K_LW: begin
        ex_c.x = addr[31:2];
      end
      K_SW: begin
        ex_c.x      = addr[31:2];
        ex_c.st_val = op_b;
      end
      K_BEQ: begin
        if (op_a == op_b) begin
          ex_c.pc_after = seq + {imm32[29:0], 2'b00};
          ex_c.taken    = 1'b1;
        end
      end
      K_J: begin
        ex_c.pc_after = {seq[31:28], s2_q.target, 2'b00};
        ex_c.taken    = 1'b1;
      end
      K_ILL: begin
        ex_c.illegal = 1'b1;
      end
      K_LDREG: begin
        ex_c.pc_after = pc_q;
        ex_c.wr_val   = s2_q.lval;
      end
      K_LDMEM: begin
        ex_c.pc_after = pc_q;
        ex_c.x        = 30'(s2_q.lidx);
        ex_c.st_val   = s2_q.lval;
      end
      default: begin
        ex_c.pc_after = pc_q;
        ex_c.wr_en    = 1'b0;
      end
    endcase
  end

  // first half of the modulo by DMEM_WORDS: reciprocal multiply
  assign mul_c = {31'd0, ex_c.x} * {30'd0, RECIP};

  // ---------------- stage 3: quotient times divisor ----------------
  assign quo3 = prod3_q[60:32];
  assign qd_c = {17'd0, quo3} * {29'd0, DIV};

  // ---------------- stage 4: remainder, data memory ----------------
  assign rem_c   = ex4_q.x - qd4_q;
  assign rem_fix = (rem_c >= {13'd0, DIV}) ? (rem_c - {13'd0, DIV}) : rem_c;
  assign widx    = rem_fix[AW-1:0];
  assign st4     = (ex4_q.kind == K_SW) || (ex4_q.kind == K_LDMEM);

  assign dm_we = clr_dm || (adv && v4_q && st4);
  assign dm_wa = clr_dm ? clr_cnt_q[AW-1:0] : widx;
  assign dm_wd = clr_dm ? 32'd0 : ex4_q.st_val;

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_q[dm_wa] <= dm_wd;
    end
    if (adv) begin
      rdata_q <= dm_q[widx];
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_c = s5_q;
    if (lw5_q) begin
      out_c.mem_val = rdata_q;
      if (s5_q.reg_we) begin
        out_c.reg_val = rdata_q;
      end
    end
  end

  assign out_valid_o = v5_q;
  assign out_data_o  = out_c;

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      pc_q <= 32'd0;
    end else begin
      if (s2_load) begin
        v2_q <= q_valid_i;
      end
      if (adv) begin
        v3_q <= v2_q && !hazard;
        v4_q <= v3_q;
        v5_q <= v4_q;
      end
      if (v2_q && s2_move) begin
        pc_q <= ex_c.pc_after;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_q <= q_data_i;
    end
    if (adv) begin
      ex3_q   <= ex_c;
      prod3_q <= mul_c;
      ex4_q   <= ex3_q;
      qd4_q   <= qd_c[29:0];
      lw5_q   <= (ex4_q.kind == K_LW);
      s5_q.pc_after <= ex4_q.pc_after;
      s5_q.reg_we   <= ex4_q.wr_en;
      s5_q.reg_idx  <= ex4_q.wr_en ? ex4_q.wr_idx : 5'd0;
      s5_q.reg_val  <= ex4_q.wr_en ? ex4_q.wr_val : 32'd0;
      s5_q.mem_we   <= st4;
      s5_q.mem_idx  <= (st4 || ex4_q.kind == K_LW) ? 5'(widx) : 5'd0;
      s5_q.mem_val  <= st4 ? ex4_q.st_val : 32'd0;
      s5_q.taken    <= ex4_q.taken;
      s5_q.illegal  <= ex4_q.illegal;
    end
  end

  // ---------------- assertions ----------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(v2_q || v3_q || v4_q || v5_q || q_valid_i))
    else $error("transaction in flight during clearing sweep");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v2_q && s2_move) |=> $stable(pc_q))
    else $error("pc changed without a transaction leaving execute");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rf_we && !clr_busy_q) |-> (rf_wa != 5'd0))
    else $error("write to register zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (rem_fix < {13'd0, DIV}))
    else $error("memory index outside data memory");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hazard |=> v2_q && $stable(s2_q))
    else $error("dependent transaction left execute before load data");

endmodule

### rtl/core/mips_subset_instruction_step.sv
// Top level of the MIPS subset instruction step block: front, queue, back.
// Depends on msis_pkg, msis_front, msis_queue and msis_back.
//
// Each input transaction is one 32-bit MIPS word to execute (R-type add, sub,
// and, or, nor, slt; lw, sw, beq, j), a preload of one register or one data
// memory word, or an idle command; each yields exactly one output transaction
// with the new pc, any register or memory write, the taken flag and the illegal
// flag. Sustained rate is one transaction per clock unless the output stalls.
// A transaction leaves the two-entry queue into execute and passes through the
// multiply and remainder stages into the output register. The other exception
// to the full rate is a lw followed within two transactions by one that reads
// the loaded register: that one waits in execute until the load data comes
// out of the registered data memory read. After reset the block clears its
// register file and data memory, one entry a cycle; in_stall_o stays high
// meanwhile. Memory indexes wrap modulo DMEM_WORDS (any value from 4 to 65536).
module mips_subset_instruction_step import msis_pkg::*; #(
  parameter int unsigned DMEM_WORDS = DMEM_WORDS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic clr_busy;
  logic push;
  dec_t push_data;
  logic q_full;
  logic q_valid;
  dec_t q_data;
  logic q_pop;

  // front: accepts and classifies
  msis_front u_front (
    .valid_i     (in_valid_i),
    .stall_o     (in_stall_o),
    .data_i      (in_data_i),
    .q_full_i    (q_full),
    .clr_busy_i  (clr_busy),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples input stalls from output stalls
  msis_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  // back: state, execute, memory, output register
  msis_back #(
    .DMEM_WORDS (DMEM_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

### tb/sv/mips_subset_instruction_step_tb.sv
// Self-checking testbench for mips_subset_instruction_step: directed and random
// transactions, checked against an in-bench architectural predictor.
// Depends on msis_pkg and the mips_subset_instruction_step RTL only.
module mips_subset_instruction_step_tb import msis_pkg::*; ();

  // Opcodes and funct codes outside the supported subset, used to hit the illegal path
  localparam logic [5:0] OP_JAL = 6'd3;
  localparam logic [5:0] FN_SLL = 6'd0;

  // Run limit: far above the slowest legal run (~600 transactions with heavy stalls)
  localparam int unsigned RUN_LIMIT = 2_000_000;
  // Drain time after the last result, covers the execute/output pipeline depth
  localparam int unsigned TAIL_CYCLES = 16;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  mips_subset_instruction_step DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Architectural state mirrored by the predictor
  // ---------------------------------------------------------------------------
  logic [31:0] pc_q;
  logic [31:0] gpr  [NREGS];
  logic [31:0] dmem [DMEM_WORDS_DEF];

  // Expected retirement records, oldest first
  out_item_t retire_q [$];

  // Idle / stall percentages of the current phase
  int unsigned snd_idle_pct  = 26;
  int unsigned rcv_stall_pct = 51;

  // Bookkeeping
  int unsigned err_count   = 0;
  int unsigned n_sent      = 0;
  int unsigned n_exec      = 0;
  int unsigned n_preload   = 0;
  int unsigned n_checked   = 0;
  int unsigned n_taken     = 0;
  int unsigned n_illegal   = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #RUN_LIMIT;
    $display("mips_subset_instruction_step test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: one transaction in, one retirement record out; updates state.
  // ---------------------------------------------------------------------------
  function automatic out_item_t retire_step(in_item_t it);
    out_item_t   r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs, rt, rd;
    logic [31:0] a, b, seq, imm, res, addr;
    logic [4:0]  widx;
    logic        alu_ok;
    r    = '0;
    op   = it.instr[31:26];
    rs   = it.instr[25:21];
    rt   = it.instr[20:16];
    rd   = it.instr[15:11];
    fn   = it.instr[5:0];
    a    = gpr[rs];
    b    = gpr[rt];
    seq  = pc_q + 32'd4;
    imm  = {{16{it.instr[15]}}, it.instr[15:0]};
    addr = a + imm;
    widx = addr[6:2];        // byte address -> word index, wrapped to 32 words
    r.pc_after = pc_q;
    case (it.cmd)
      CMD_LDREG: begin
        if (it.load_index != 5'd0) begin
          gpr[it.load_index] = it.load_value;
          r.reg_we  = 1'b1;
          r.reg_idx = it.load_index;
          r.reg_val = it.load_value;
        end
      end
      CMD_LDMEM: begin
        dmem[it.load_index] = it.load_value;
        r.mem_we  = 1'b1;
        r.mem_idx = it.load_index;
        r.mem_val = it.load_value;
      end
      CMD_EXEC: begin
        r.pc_after = seq;
        case (op)
          OP_RTYPE: begin
            alu_ok = 1'b1;
            case (fn)
              FN_ADD:  res = a + b;
              FN_SUB:  res = a - b;
              FN_AND:  res = a & b;
              FN_OR:   res = a | b;
              FN_NOR:  res = ~(a | b);
              FN_SLT:  res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
              default: begin
                alu_ok = 1'b0;
                res    = '0;
              end
            endcase
            if (!alu_ok) begin
              r.illegal = 1'b1;
            end else if (rd != 5'd0) begin
              gpr[rd]   = res;
              r.reg_we  = 1'b1;
              r.reg_idx = rd;
              r.reg_val = res;
            end
          end
          OP_LW: begin
            r.mem_idx = widx;
            r.mem_val = dmem[widx];
            if (rt != 5'd0) begin
              gpr[rt]   = dmem[widx];
              r.reg_we  = 1'b1;
              r.reg_idx = rt;
              r.reg_val = dmem[widx];
            end
          end
          OP_SW: begin
            dmem[widx] = b;
            r.mem_we   = 1'b1;
            r.mem_idx  = widx;
            r.mem_val  = b;
          end
          OP_BEQ: begin
            if (a == b) begin
              r.pc_after = seq + (imm << 2);
              r.taken    = 1'b1;
            end
          end
          OP_J: begin
            r.pc_after = {seq[31:28], it.instr[25:0], 2'b00};
            r.taken    = 1'b1;
          end
          default: r.illegal = 1'b1;
        endcase
        pc_q = r.pc_after;
      end
      default: ;             // command code three: nothing changes
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Encoders and random field sources
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] shamt);
    return {OP_RTYPE, rs, rt, rd, shamt, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(logic [25:0] target);
    return {OP_J, target};
  endfunction

  function automatic in_item_t exec_item(logic [31:0] instr);
    in_item_t it;
    it.cmd        = CMD_EXEC;
    it.instr      = instr;
    it.load_index = 5'($urandom_range(31));   // unused fields carry noise
    it.load_value = $urandom();
    return it;
  endfunction

  function automatic in_item_t load_item(cmd_e cmd, logic [4:0] idx, logic [31:0] val);
    in_item_t it;
    it.cmd        = cmd;
    it.instr      = $urandom();
    it.load_index = idx;
    it.load_value = val;
    return it;
  endfunction

  // Mostly a small register window so load-use and beq-equal cases come up often
  function automatic logic [4:0] rand_reg();
    if ($urandom_range(99) < 70) return 5'($urandom_range(7));
    return 5'($urandom_range(31));
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [5:0] rand_alu_fn();
    case ($urandom_range(5))
      0:       return FN_ADD;
      1:       return FN_SUB;
      2:       return FN_AND;
      3:       return FN_OR;
      4:       return FN_NOR;
      default: return FN_SLT;
    endcase
  endfunction

  // Well-formed programs with random content, plus preloads and noise
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    logic [5:0]  code;
    logic [4:0]  rs;
    logic [15:0] off;
    pick = $urandom_range(99);
    rs   = rand_reg();
    off  = ($urandom_range(1) == 1) ? 16'($urandom()) : 16'($signed($urandom_range(16)) - 8);
    if (pick < 8) begin
      it = load_item(CMD_LDREG, 5'($urandom_range(31)), rand_word());
    end else if (pick < 12) begin
      it = load_item(CMD_LDMEM, 5'($urandom_range(31)), rand_word());
    end else if (pick < 14) begin
      it = load_item(CMD_NONE, 5'($urandom_range(31)), $urandom());
    end else if (pick < 50) begin
      it = exec_item(enc_r(rand_alu_fn(), rs, rand_reg(), rand_reg(),
                           5'($urandom_range(31))));
    end else if (pick < 62) begin
      it = exec_item(enc_i(OP_LW, rs, rand_reg(), 16'($urandom())));
    end else if (pick < 74) begin
      it = exec_item(enc_i(OP_SW, rs, rand_reg(), 16'($urandom())));
    end else if (pick < 84) begin
      // half of the branches compare a register with itself
      it = exec_item(enc_i(OP_BEQ, rs, ($urandom_range(1) == 1) ? rs : rand_reg(), off));
    end else if (pick < 88) begin
      it = exec_item(enc_j(26'($urandom())));
    end else if (pick < 93) begin
      code = 6'($urandom_range(63));
      while (code inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_NOR, FN_SLT})
        code = 6'($urandom_range(63));
      it = exec_item(enc_r(code, rs, rand_reg(), rand_reg(), 5'($urandom_range(31))));
    end else if (pick < 97) begin
      code = 6'($urandom_range(63));
      while (code inside {OP_RTYPE, OP_J, OP_BEQ, OP_LW, OP_SW})
        code = 6'($urandom_range(63));
      it = exec_item(enc_i(code, rs, rand_reg(), 16'($urandom())));
    end else begin
      it = exec_item($urandom());
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: present one transaction, hold it until accepted, then predict.
  // Called back to back with no idle drawn, valid stays high without a low glitch.
  // ---------------------------------------------------------------------------
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // accepted at this edge
    retire_q.push_back(retire_step(it));
    n_sent++;
    if (it.cmd == CMD_EXEC) n_exec++;
    else if (it.cmd != CMD_NONE) n_preload++;
  endtask

  // Sender holds off until every outstanding transaction has retired
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall and in-order check of every accepted result
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp, act);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (retire_q.size() == 0) begin
        $error("unexpected result transaction, pc_after 0x%08h", out_data_o.pc_after);
        err_count++;
      end else begin
        want = retire_q.pop_front();
        n_checked++;
        if (want.taken)   n_taken++;
        if (want.illegal) n_illegal++;
        check_field("pc_after", want.pc_after, out_data_o.pc_after);
        check_field("reg_we",   32'(want.reg_we),  32'(out_data_o.reg_we));
        check_field("reg_idx",  32'(want.reg_idx), 32'(out_data_o.reg_idx));
        check_field("reg_val",  want.reg_val,  out_data_o.reg_val);
        check_field("mem_we",   32'(want.mem_we),  32'(out_data_o.mem_we));
        check_field("mem_idx",  32'(want.mem_idx), 32'(out_data_o.mem_idx));
        check_field("mem_val",  want.mem_val,  out_data_o.mem_val);
        check_field("taken",    32'(want.taken),   32'(out_data_o.taken));
        check_field("illegal",  32'(want.illegal), 32'(out_data_o.illegal));
      end
    end
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register and memory preloads, r0 write dropped, idle command code
  task automatic test_preloads();
    send_item(load_item(CMD_LDREG, 5'd0,  32'hDEAD_BEEF));
    send_item(load_item(CMD_LDREG, 5'd1,  32'hFFFF_FFFF));
    send_item(load_item(CMD_LDREG, 5'd2,  32'h8000_0000));
    send_item(load_item(CMD_LDREG, 5'd3,  32'h7FFF_FFFF));
    send_item(load_item(CMD_LDMEM, 5'd31, 32'hA5A5_5A5A));
    send_item(load_item(CMD_LDMEM, 5'd0,  32'h0000_0001));
    send_item(load_item(CMD_NONE,  5'd31, 32'hFFFF_FFFF));
  endtask

  // Every ALU funct, wraparound, signed compare both ways, shamt ignored, r0 dropped
  task automatic test_alu_ops();
    send_item(exec_item(enc_r(FN_ADD, 5'd1, 5'd3, 5'd4,  5'd31)));
    send_item(exec_item(enc_r(FN_SUB, 5'd2, 5'd3, 5'd5,  5'd0)));
    send_item(exec_item(enc_r(FN_AND, 5'd1, 5'd2, 5'd6,  5'd7)));
    send_item(exec_item(enc_r(FN_OR,  5'd2, 5'd3, 5'd7,  5'd0)));
    send_item(exec_item(enc_r(FN_NOR, 5'd0, 5'd0, 5'd8,  5'd0)));
    send_item(exec_item(enc_r(FN_SLT, 5'd2, 5'd3, 5'd9,  5'd0)));
    send_item(exec_item(enc_r(FN_SLT, 5'd3, 5'd2, 5'd10, 5'd0)));
    send_item(exec_item(enc_r(FN_ADD, 5'd1, 5'd1, 5'd0,  5'd0)));
  endtask

  // Negative offset wrap, unaligned address, load into r0, load-use back to back
  task automatic test_memory_ops();
    send_item(exec_item(enc_i(OP_SW, 5'd0, 5'd1,  16'hFFFC)));
    send_item(exec_item(enc_i(OP_LW, 5'd0, 5'd11, 16'h7FFF)));
    send_item(exec_item(enc_r(FN_ADD, 5'd11, 5'd11, 5'd12, 5'd0)));
    send_item(exec_item(enc_i(OP_LW, 5'd0, 5'd0,  16'h0000)));
  endtask

  // Backward branch wrapping pc, untaken branch, jumps across the region boundary
  task automatic test_control_flow();
    send_item(exec_item(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000)));
    send_item(exec_item(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h0005)));
    send_item(exec_item(enc_j(26'h3FF_FFFF)));
    send_item(exec_item(enc_j(26'h000_0000)));
  endtask

  // jal, a shift funct and an all-ones word are all unsupported
  task automatic test_illegal_words();
    send_item(exec_item({OP_JAL, 26'h123_4567}));
    send_item(exec_item(enc_r(FN_SLL, 5'd1, 5'd2, 5'd13, 5'd4)));
    send_item(exec_item(32'hFFFF_FFFF));
  endtask

  // One random phase at the given idle mix, then a full drain
  task automatic test_random_traffic(int unsigned count, int unsigned snd_pct,
                                     int unsigned rcv_pct);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    repeat (count) send_item(random_item());
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    pc_q = '0;
    foreach (gpr[i])  gpr[i]  = '0;
    foreach (dmem[i]) dmem[i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block clears its storage after reset; send_item waits out the stall

    test_preloads();
    test_alu_ops();
    test_memory_ops();
    test_control_flow();
    test_illegal_words();
    drain_results();

    test_random_traffic(184, 26, 51);
    test_random_traffic(183, 51, 26);
    test_random_traffic(183, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d transactions (%0d executes, %0d preloads) under three idle mixes.",
             n_sent, n_exec, n_preload);
    $display("Checked %0d results: %0d taken branches or jumps, %0d unsupported words.",
             n_checked, n_taken, n_illegal);
    if (err_count == 0 && retire_q.size() == 0) begin
      $display("mips_subset_instruction_step test passed");
    end else begin
      $display("mips_subset_instruction_step test failed");
    end
    $finish;
  end

endmodule
